/* rtl/printable_run_extractor_macros.svh */
// Assertion macros for the printable run extractor.
// Included by the top level only; the macros expect signals named clk and rst in scope.
`ifndef PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pre_pkg.sv */
// Package for the printable run extractor: command and status types and fixed constants.
// No dependencies; the queue, front end, back end and top level refer to it by scoped names.
package pre_pkg;

  // Fixed field widths of the result words.
  localparam int CNT_BITS   = 32;
  localparam int START_BITS = 32;
  localparam int MIN_BITS   = 6;
  // Wide enough for a held-byte count at the largest supported lookback depth.
  localparam int HELD_BITS  = 6;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MIN_BITS-1:0] MIN_LEN_RESET = 6'd4;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // One unit of work for the back end: a character (preceded by held bytes) or a record.
  typedef struct packed {
    logic                  kind;
    logic [7:0]            char_byte;
    logic [HELD_BITS-1:0]  held;
    logic [START_BITS-1:0] start;
    logic [CNT_BITS-1:0]   length;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic burst_done;
  } back_status_t;

endpackage

/* rtl/pre_if.sv */
// Stream interfaces of the printable run extractor: input bytes and result words.
// Depends on nothing but the field widths of the block.
interface pre_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface pre_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_out;
  logic [31:0] start_offset;
  logic [31:0] run_length;
  logic        last;

  modport source (output valid, output kind, output char_out, output start_offset,
                  output run_length, output last, input ready);
  modport sink (input valid, input kind, input char_out, input start_offset,
                input run_length, input last, output ready);
endinterface

/* rtl/pre_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pre_queue.sv */
// Short command queue between the front and back ends of the printable run extractor.
// Depends on pre_pkg for the command type and the queue depth.
module pre_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pre_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output pre_pkg::cmd_t head,
  output logic          nonempty
);

  localparam int PW = (pre_pkg::QUEUE_DEPTH > 1) ? $clog2(pre_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(pre_pkg::QUEUE_DEPTH + 1);

  pre_pkg::cmd_t entries [pre_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(pre_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(pre_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(pre_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/pre_front.sv */
// Front end of the printable run extractor: accepts bytes, tracks the run and offsets,
// fills the lookback store and queues commands. Depends on pre_pkg and pre_in_if.
module pre_front #(
  parameter int MAX_MIN_LEN = 32,
  parameter int OFFSET_BITS = 32,
  parameter int AW          = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  pre_in_if.sink                        byte_in,
  input  logic [pre_pkg::MIN_BITS-1:0]  min_len,
  input  pre_pkg::back_status_t         status,
  input  logic                          q_full,
  output logic                          q_push,
  output pre_pkg::cmd_t                 q_cmd,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [7:0]                    ram_wdata
);

  localparam int THR_BITS = $clog2(MAX_MIN_LEN + 1);

  logic [pre_pkg::CNT_BITS-1:0]   run_count;
  logic [pre_pkg::START_BITS-1:0] run_start;
  logic [OFFSET_BITS-1:0]         stream_offset;
  logic                           reporting;
  logic                           burst_pending;

  logic [THR_BITS-1:0]            thr;
  logic                           accept;
  logic                           printable;
  logic                           reached;
  logic [pre_pkg::START_BITS-1:0] start_now;

  assign byte_in.ready = !q_full && !burst_pending;
  assign accept        = byte_in.valid && byte_in.ready;
  assign printable     = (byte_in.data_byte >= pre_pkg::PRINT_LO) &&
                         (byte_in.data_byte <= pre_pkg::PRINT_HI);

  always_comb begin
    if (min_len == '0) begin
      thr = THR_BITS'(1);
    end else if (32'(min_len) > 32'(MAX_MIN_LEN)) begin
      thr = THR_BITS'(MAX_MIN_LEN);
    end else begin
      thr = THR_BITS'(min_len);
    end
  end

  assign reached   = run_count >= (32'(thr) - 32'd1);
  assign start_now = (run_count == '0) ? pre_pkg::START_BITS'(stream_offset) : run_start;

  always_comb begin
    q_push    = 1'b0;
    q_cmd     = '0;
    ram_we    = 1'b0;
    ram_waddr = AW'(run_count);
    ram_wdata = byte_in.data_byte;
    if (accept) begin
      if (byte_in.operation == pre_pkg::OP_DATA && printable) begin
        q_cmd.kind      = pre_pkg::KIND_CHAR;
        q_cmd.char_byte = byte_in.data_byte;
        q_cmd.start     = start_now;
        if (reporting) begin
          q_push = 1'b1;
        end else if (reached) begin
          // An unreported run never grows past the lookback depth, so the count fits.
          q_push     = 1'b1;
          q_cmd.held = pre_pkg::HELD_BITS'(run_count);
        end else if (run_count < 32'(MAX_MIN_LEN - 1)) begin
          ram_we = 1'b1;
        end
      end else if (reporting) begin
        q_push       = 1'b1;
        q_cmd.kind   = pre_pkg::KIND_RECORD;
        q_cmd.start  = run_start;
        q_cmd.length = run_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      run_start     <= '0;
      stream_offset <= '0;
      reporting     <= 1'b0;
      burst_pending <= 1'b0;
    end else begin
      if (status.burst_done) begin
        burst_pending <= 1'b0;
      end
      if (accept) begin
        if (byte_in.operation == pre_pkg::OP_EOS) begin
          run_count     <= '0;
          reporting     <= 1'b0;
          stream_offset <= '0;
        end else begin
          stream_offset <= stream_offset + OFFSET_BITS'(1);
          if (printable) begin
            run_start <= start_now;
            if (run_count != '1) begin
              run_count <= run_count + 32'd1;
            end
            if (!reporting && reached) begin
              reporting <= 1'b1;
              if (run_count != '0) begin
                burst_pending <= 1'b1;
              end
            end
          end else begin
            run_count <= '0;
            reporting <= 1'b0;
          end
        end
      end
    end
  end

endmodule

/* rtl/pre_back.sv */
// Back end of the printable run extractor: replays held bytes from the lookback store
// and drives the registered result port. Depends on pre_pkg and pre_out_if.
module pre_back #(
  parameter int AW = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  pre_pkg::cmd_t         q_head,
  output logic                  q_pop,
  output logic [AW-1:0]         ram_raddr,
  input  logic [7:0]            ram_rdata,
  output pre_pkg::back_status_t status,
  pre_out_if.source             result_out
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [pre_pkg::HELD_BITS-1:0] idx;
  logic [pre_pkg::HELD_BITS-1:0] idx_next;
  pre_pkg::cmd_t                 cur;

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_char;
  logic [31:0] out_start;
  logic [31:0] out_len;
  logic        out_last;

  logic        out_free;
  logic        load;
  logic        ld_kind;
  logic [7:0]  ld_char;
  logic [31:0] ld_start;
  logic [31:0] ld_len;
  logic        ld_last;
  logic        burst_done;

  assign out_free = !out_valid || result_out.ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_pop      = 1'b0;
    load       = 1'b0;
    ld_kind    = pre_pkg::KIND_CHAR;
    ld_char    = '0;
    ld_start   = cur.start;
    ld_len     = '0;
    ld_last    = 1'b1;
    burst_done = 1'b0;
    case (state)
      ST_RUN: begin
        if (q_valid) begin
          if (q_head.kind == pre_pkg::KIND_CHAR && q_head.held != '0) begin
            q_pop      = 1'b1;
            state_next = ST_BURST;
            idx_next   = '0;
          end else if (out_free) begin
            q_pop    = 1'b1;
            load     = 1'b1;
            ld_kind  = q_head.kind;
            ld_char  = q_head.char_byte;
            ld_start = q_head.start;
            ld_len   = q_head.length;
          end
        end
      end
      ST_BURST: begin
        if (out_free) begin
          load = 1'b1;
          if (idx != cur.held) begin
            ld_char  = ram_rdata;
            ld_last  = 1'b0;
            idx_next = idx + pre_pkg::HELD_BITS'(1);
          end else begin
            ld_char    = cur.char_byte;
            state_next = ST_RUN;
            burst_done = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // The read address follows the next index so the data is ready when the index moves.
  assign ram_raddr = AW'(idx_next);

  assign status.busy       = (state == ST_BURST);
  assign status.burst_done = burst_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && state == ST_RUN) begin
      cur <= q_head;
    end
    if (load) begin
      out_kind  <= ld_kind;
      out_char  <= ld_char;
      out_start <= ld_start;
      out_len   <= ld_len;
      out_last  <= ld_last;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.kind         = out_kind;
  assign result_out.char_out     = out_char;
  assign result_out.start_offset = out_start;
  assign result_out.run_length   = out_len;
  assign result_out.last         = out_last;

endmodule

/* rtl/printable_run_extractor.sv */
// Printable run extractor: finds runs of printable bytes (0x20 to 0x7E) in a byte
// stream and reports those of at least min_len bytes. Each accepted input word is
// handled by the front end; a result word reaches the output through the command queue
// and the output register. The output delivers one word per cycle while drained.
// When a run first reaches min_len, its held leading bytes are replayed from the
// lookback RAM through its single read port: the back end takes the command in a set-up
// step, then replays the bytes, and the input is held off (ready low) from the word that
// starts the burst until the last byte of that burst has been registered at the
// output. Outside bursts the block takes one byte per cycle as long as the output is
// drained. The lookback RAM needs no clearing after reset, since only bytes written
// earlier in the same run are ever read. Run lengths saturate at 2^32-1; the stream
// offset wraps at OFFSET_BITS and its low 32 bits are reported. An end-of-stream word
// closes any reported run with a record and sets the offset back to zero. The user must
// write min_len through cfg_we and cfg_wdata only while the block is idle; the block
// does not enforce it. Zero acts as one, values above MAX_MIN_LEN as MAX_MIN_LEN.
`include "printable_run_extractor_macros.svh"

module printable_run_extractor #(
  parameter int MAX_MIN_LEN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pre_pkg::MIN_BITS-1:0] cfg_wdata,
  pre_in_if.sink                       byte_in,
  pre_out_if.source                    result_out
);

  // Address width of the lookback RAM, which holds up to MAX_MIN_LEN-1 bytes.
  localparam int LB_DEPTH = MAX_MIN_LEN - 1;
  localparam int AW       = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;

  logic [pre_pkg::MIN_BITS-1:0] min_len;

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  pre_pkg::cmd_t         q_cmd;
  pre_pkg::cmd_t         q_head;
  pre_pkg::back_status_t status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // The threshold register is the only configuration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= pre_pkg::MIN_LEN_RESET;
    end else if (cfg_we) begin
      min_len <= cfg_wdata;
    end
  end

  // The front end owns all run state and decides, per word, what the back end must emit.
  pre_front #(
    .MAX_MIN_LEN (MAX_MIN_LEN),
    .OFFSET_BITS (OFFSET_BITS),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .min_len   (min_len),
    .status    (status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // The queue lets the front end carry on while the output is stalled.
  pre_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_valid)
  );

  // Lookback store: written by the front end, read back by the back end during a burst.
  pre_ram #(
    .WIDTH (8),
    .DEPTH (LB_DEPTH)
  ) u_lookback (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pre_back #(
    .AW (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .status     (status),
    .result_out (result_out)
  );

  // The queue must never be asked to take a command it has no room for.
  `PRE_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "command pushed into a full queue")
  // The lookback bytes being replayed must not be overwritten by a new run.
  `PRE_ASSERT_SAME(a_no_write_in_burst, status.busy, !ram_we, "lookback written during a burst")
  // A record is a single result and therefore always the last word of its input.
  `PRE_ASSERT_SAME(a_record_is_last, result_out.valid && result_out.kind, result_out.last,
    "end-of-string record without last")
  // Once a burst completes the back end is ready for the next command.
  `PRE_ASSERT_NEXT(a_burst_ends, status.burst_done, !status.busy, "back end still busy after burst")

endmodule
